// ===== rtl/lpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line pixel generator: payload structs,
// register indexes, request and depth codes.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // Coordinate width of the rasterizer (cursors wrap at this width).
    localparam int COORD_BITS = 10;
    // Error term carries two bits beyond a coordinate (sign plus headroom).
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int STRIDE_BITS = 11;
    localparam int ADDR_BITS  = 32;
    localparam int COLOR_BITS = 24;
    localparam int DATA_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int DEPTH_BITS = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_MODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH = 2'd2;

    // Depth codes.
    localparam logic [DEPTH_BITS-1:0] DEPTH_RGB565 = 2'd0;
    localparam logic [DEPTH_BITS-1:0] DEPTH_BYTE   = 2'd1;

    // Request codes.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Register reset values.
    localparam logic [STRIDE_BITS-1:0] LINE_WIDTH_RESET = 11'd480;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] rgb_color;
    } req_t;

    typedef struct packed {
        logic                 pixel_valid;
        logic [ADDR_BITS-1:0] pixel_address;
        logic [DATA_BITS-1:0] pixel_data;
        logic                 last_pixel;
    } pix_t;

endpackage

// ===== rtl/line_pixel_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// Eight-octant Bresenham line engine producing frame buffer pixel writes.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Direction | Moves per transfer
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_data      | input     | one request (req_t)
//  out     | out_valid, out_ready, out_data   | output    | one pixel (pix_t)
//  cfg     | cfg_valid, cfg_ready, cfg_index, | input     | one register write
//          | cfg_data                         |           |
//
// One request is accepted per cycle while in_ready is high and gives exactly
// one pixel transfer, carried by the Bresenham step at accept, the row multiply
// in the second stage and the base add in the output register.
// Each pipeline stage loads whenever it is empty or its successor moves, so
// while a finished pixel waits at the output, two more requests are still
// taken to fill the empty stages before in_ready drops.
// Reset (rst_n low, asynchronous) empties the pipeline, ends any active line
// and returns the registers to base 0, 16-bit mode and a stride of 480.
// Configuration writes are always taken (cfg_ready is tied high).
//
module line_pixel_generator_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lpg_pkg::req_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output lpg_pkg::pix_t                         out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [lpg_pkg::ADDR_BITS-1:0]         cfg_data
);

    localparam int CB = lpg_pkg::COORD_BITS;
    localparam int EB = lpg_pkg::ERR_BITS;
    localparam int SB = lpg_pkg::STRIDE_BITS;
    localparam int AB = lpg_pkg::ADDR_BITS;
    localparam int DB = lpg_pkg::DATA_BITS;
    // Row index y*stride + x needs one bit beyond the product.
    localparam int IB = CB + SB + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [AB-1:0]                  frame_base_reg;
    logic [lpg_pkg::DEPTH_BITS-1:0] depth_mode_reg;
    logic [SB-1:0]                  line_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            depth_mode_reg <= lpg_pkg::DEPTH_RGB565;
            line_width_reg <= lpg_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes to an index beyond the register list are dropped.
            if (cfg_index == lpg_pkg::CFG_FRAME_BASE)
                frame_base_reg <= cfg_data;
            else if (cfg_index == lpg_pkg::CFG_DEPTH_MODE)
                depth_mode_reg <= cfg_data[lpg_pkg::DEPTH_BITS-1:0];
            else if (cfg_index == lpg_pkg::CFG_LINE_WIDTH)
                line_width_reg <= cfg_data[SB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s1_load, s2_load, out_load, in_accept;

    assign out_load  = !out_valid_reg || out_ready;
    assign s2_load   = !s2_valid_reg || out_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign in_ready  = s1_load;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Line state. The cursor holds the pixel that was emitted last; a
    // tick first advances it one Bresenham step and then emits it.
    // ------------------------------------------------------------------
    logic          line_active_reg, line_active_next;
    logic [CB-1:0] cursor_x_reg, cursor_x_next;
    logic [CB-1:0] cursor_y_reg, cursor_y_next;
    logic [CB-1:0] stop_major_reg, stop_major_next;
    logic [CB-1:0] delta_major_reg, delta_major_next;
    logic [CB-1:0] delta_minor_reg, delta_minor_next;
    logic [EB-1:0] error_term_reg, error_term_next;
    logic          x_dec_reg, x_dec_next;
    logic          y_dec_reg, y_dec_next;
    logic          y_major_reg, y_major_next;
    logic [DB-1:0] latched_color_reg, latched_color_next;

    // Values of the pixel that the accepted request emits.
    logic          emit_zero;
    logic [CB-1:0] emit_x, emit_y;
    logic          emit_last;
    logic [DB-1:0] emit_data;

    // Start decode.
    logic          st_x_dec, st_y_dec, st_y_major;
    logic [CB-1:0] st_adx, st_ady;
    logic [CB-1:0] st_major, st_minor, st_stop;
    logic [DB-1:0] st_color;
    logic [lpg_pkg::COLOR_BITS-1:0] c;

    // Tick step.
    logic          tk_step_minor;
    logic [CB-1:0] tk_x, tk_y;
    logic [EB-1:0] tk_err;

    always_comb
    begin
        c          = in_data.rgb_color;
        st_x_dec   = in_data.end_x < in_data.start_x;
        st_y_dec   = in_data.end_y < in_data.start_y;
        st_adx     = st_x_dec ? in_data.start_x - in_data.end_x
                              : in_data.end_x - in_data.start_x;
        st_ady     = st_y_dec ? in_data.start_y - in_data.end_y
                              : in_data.end_y - in_data.start_y;
        st_y_major = st_adx < st_ady;
        st_major   = st_y_major ? st_ady : st_adx;
        st_minor   = st_y_major ? st_adx : st_ady;
        st_stop    = st_y_major ? in_data.end_y : in_data.end_x;

        // Color is packed with the depth in force at the start request.
        if (depth_mode_reg == lpg_pkg::DEPTH_RGB565)
            st_color = {c[23:19], c[15:10], c[7:3]};
        else if (depth_mode_reg == lpg_pkg::DEPTH_BYTE)
            st_color = {8'h00, c[7:0]};
        else
            st_color = '0;

        // The minor axis moves when the error is strictly positive.
        tk_step_minor = !error_term_reg[EB-1] && (error_term_reg != '0);
        tk_x = cursor_x_reg;
        tk_y = cursor_y_reg;
        if (y_major_reg)
        begin
            tk_y = y_dec_reg ? cursor_y_reg - 1'b1 : cursor_y_reg + 1'b1;
            if (tk_step_minor)
                tk_x = x_dec_reg ? cursor_x_reg - 1'b1 : cursor_x_reg + 1'b1;
        end
        else
        begin
            tk_x = x_dec_reg ? cursor_x_reg - 1'b1 : cursor_x_reg + 1'b1;
            if (tk_step_minor)
                tk_y = y_dec_reg ? cursor_y_reg - 1'b1 : cursor_y_reg + 1'b1;
        end
        tk_err = error_term_reg
               - (tk_step_minor ? EB'(delta_major_reg) : '0)
               + EB'(delta_minor_reg);

        line_active_next   = line_active_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        stop_major_next    = stop_major_reg;
        delta_major_next   = delta_major_reg;
        delta_minor_next   = delta_minor_reg;
        error_term_next    = error_term_reg;
        x_dec_next         = x_dec_reg;
        y_dec_next         = y_dec_reg;
        y_major_next       = y_major_reg;
        latched_color_next = latched_color_reg;

        emit_zero = 1'b0;
        emit_x    = tk_x;
        emit_y    = tk_y;
        emit_last = 1'b0;
        emit_data = latched_color_reg;

        if (in_data.req_type == lpg_pkg::REQ_START)
        begin
            // A start drops any running line and emits its first point.
            emit_x    = in_data.start_x;
            emit_y    = in_data.start_y;
            emit_last = (st_y_major ? in_data.start_y : in_data.start_x) == st_stop;
            emit_data = st_color;

            line_active_next   = !emit_last;
            cursor_x_next      = in_data.start_x;
            cursor_y_next      = in_data.start_y;
            stop_major_next    = st_stop;
            delta_major_next   = st_major;
            delta_minor_next   = st_minor;
            error_term_next    = EB'(st_minor) - EB'(st_major >> 1);
            x_dec_next         = st_x_dec;
            y_dec_next         = st_y_dec;
            y_major_next       = st_y_major;
            latched_color_next = st_color;
        end
        else if (line_active_reg)
        begin
            emit_last        = (y_major_reg ? tk_y : tk_x) == stop_major_reg;
            line_active_next = !emit_last;
            cursor_x_next    = tk_x;
            cursor_y_next    = tk_y;
            error_term_next  = tk_err;
        end
        else
        begin
            // A tick with no line running gives an all-zero pixel.
            emit_zero = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg   <= 1'b0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            stop_major_reg    <= '0;
            delta_major_reg   <= '0;
            delta_minor_reg   <= '0;
            error_term_reg    <= '0;
            x_dec_reg         <= 1'b0;
            y_dec_reg         <= 1'b0;
            y_major_reg       <= 1'b0;
            latched_color_reg <= '0;
        end
        else if (in_accept)
        begin
            line_active_reg   <= line_active_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            stop_major_reg    <= stop_major_next;
            delta_major_reg   <= delta_major_next;
            delta_minor_reg   <= delta_minor_next;
            error_term_reg    <= error_term_next;
            x_dec_reg         <= x_dec_next;
            y_dec_reg         <= y_dec_next;
            y_major_reg       <= y_major_next;
            latched_color_reg <= latched_color_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: emitted pixel coordinates and flags.
    // ------------------------------------------------------------------
    logic          s1_zero_reg, s1_last_reg;
    logic [CB-1:0] s1_x_reg, s1_y_reg;
    logic [DB-1:0] s1_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_zero_reg <= emit_zero;
            s1_last_reg <= emit_last;
            s1_x_reg    <= emit_x;
            s1_y_reg    <= emit_y;
            s1_data_reg <= emit_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row index y * stride + x.
    // ------------------------------------------------------------------
    logic          s2_zero_reg, s2_last_reg;
    logic [IB-1:0] s2_idx_reg;
    logic [DB-1:0] s2_data_reg;
    logic [IB-1:0] s2_idx_next;

    assign s2_idx_next = IB'(s1_y_reg) * IB'(line_width_reg) + IB'(s1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_last_reg <= s1_last_reg;
            s2_idx_reg  <= s2_idx_next;
            s2_data_reg <= s1_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: byte address and depth gating. The depth in force
    // at each pixel selects the scale.
    // ------------------------------------------------------------------
    lpg_pkg::pix_t out_data_reg, out_data_next;
    logic [AB-1:0] offset;

    always_comb
    begin
        offset        = AB'(s2_idx_reg);
        out_data_next = '0;
        if (!s2_zero_reg)
        begin
            out_data_next.last_pixel = s2_last_reg;
            if (depth_mode_reg == lpg_pkg::DEPTH_RGB565)
            begin
                out_data_next.pixel_valid   = 1'b1;
                out_data_next.pixel_address = frame_base_reg + (offset << 1);
                out_data_next.pixel_data    = s2_data_reg;
            end
            else if (depth_mode_reg == lpg_pkg::DEPTH_BYTE)
            begin
                out_data_next.pixel_valid   = 1'b1;
                out_data_next.pixel_address = frame_base_reg + offset;
                out_data_next.pixel_data    = s2_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s2_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_idle_tick_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_zero_reg |-> !s1_last_reg)
        else $error("idle tick marked as last pixel");

    a_write_needs_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.pixel_valid |->
            (depth_mode_reg == lpg_pkg::DEPTH_RGB565) ||
            (depth_mode_reg == lpg_pkg::DEPTH_BYTE))
        else $error("pixel write issued under unsupported depth");

    a_point_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (in_data.req_type == lpg_pkg::REQ_START) &&
        (in_data.start_x == in_data.end_x) && (in_data.start_y == in_data.end_y)
        |=> !line_active_reg && s1_valid_reg && s1_last_reg)
        else $error("single point start did not end the line");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (in_data.req_type == lpg_pkg::REQ_TICK) && !line_active_reg
        |=> $stable(cursor_x_reg) && $stable(cursor_y_reg) && !line_active_reg)
        else $error("idle tick moved the cursor");

endmodule
